// File: hdl/multi_channel_soft_pwm_assert.svh
// assertion macros for the soft pwm block
// each macro takes a label, clock, active-low reset, a condition and a consequence
`ifndef MULTI_CHANNEL_SOFT_PWM_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_PWM_ASSERT_SVH

`ifndef SYNTHESIS

// consequence must hold in the same cycle as the condition
`define MCPWM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mcpwm assertion failed");

// consequence must hold in the cycle after the condition
`define MCPWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mcpwm assertion failed");

`else

`define MCPWM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MCPWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/mcpwm_pkg.sv
`default_nettype none

package mcpwm_pkg;

    // table geometry
    localparam int TABLE_DEPTH  = 8;
    localparam int SLOT_W       = 3;
    localparam int COUNT_W      = 4;
    localparam int PIN_W        = 8;
    localparam int DUTY_W       = 8;
    localparam int DEF_CHANNELS = 8;

    // request codes
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kind codes
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_LEVEL  = 1'b1;

    // set-duty status codes
    localparam logic [1:0] STAT_UPDATED   = 2'd0;
    localparam logic [1:0] STAT_ALLOCATED = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // one channel table entry
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [DUTY_W-1:0] duty;
    } entry_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

// File: hdl/mcpwm_ram.sv
`default_nettype none

module mcpwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/multi_channel_soft_pwm.sv
// tick: one level per used channel, one per cycle; none on an empty table
// set duty: table walked one slot per cycle
// next transaction taken once busy is low, none while a scan runs; paced by the table read port
// reset clears phase, channel count and sequencer; table memory is not cleared
`default_nettype none

`include "multi_channel_soft_pwm_assert.svh"

module multi_channel_soft_pwm #(
    parameter int CHANNELS = mcpwm_pkg::DEF_CHANNELS
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire                             req_type,
    input  wire  [mcpwm_pkg::PIN_W-1:0]     pin_id,
    input  wire  [mcpwm_pkg::DUTY_W-1:0]    duty,
    output logic                            valid,
    output logic                            kind,
    output logic [1:0]                      status,
    output logic [mcpwm_pkg::SLOT_W-1:0]    slot,
    output logic [mcpwm_pkg::PIN_W-1:0]     out_pin,
    output logic                            level,
    output logic                            last
);

    localparam int SLOT_W  = mcpwm_pkg::SLOT_W;
    localparam int COUNT_W = mcpwm_pkg::COUNT_W;
    localparam int CAP_INT = (CHANNELS < mcpwm_pkg::TABLE_DEPTH) ? CHANNELS
                                                                 : mcpwm_pkg::TABLE_DEPTH;
    localparam logic [COUNT_W-1:0] TABLE_CAP = COUNT_W'(CAP_INT);

    mcpwm_pkg::state_t state_reg, state_next;

    logic                           req_reg;
    logic [mcpwm_pkg::PIN_W-1:0]    pin_reg;
    logic [mcpwm_pkg::DUTY_W-1:0]   duty_reg;
    logic [7:0]                     phase_reg, phase_next;
    logic [COUNT_W-1:0]             used_reg, used_next;
    logic [COUNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]              chk_idx_reg;

    logic                           valid_reg, valid_next;
    logic                           kind_reg, kind_next;
    logic [1:0]                     status_reg, status_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic [mcpwm_pkg::PIN_W-1:0]    pin_out_reg, pin_out_next;
    logic                           level_reg, level_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic                           ram_we;
    logic [SLOT_W-1:0]              ram_waddr;
    mcpwm_pkg::entry_t              ram_wdata;
    logic                           ram_re;
    logic [SLOT_W-1:0]              ram_raddr;
    mcpwm_pkg::entry_t              ram_rdata;
    logic                           used_inc;

    logic                           hit;
    logic                           exhausted;
    logic                           tick_last;
    logic                           scan_done;

    assign accept = start && (state_reg == mcpwm_pkg::ST_IDLE);
    assign busy   = (state_reg != mcpwm_pkg::ST_IDLE);

    // channel table: pin and duty per slot
    mcpwm_ram #(
        .WIDTH ($bits(mcpwm_pkg::entry_t)),
        .DEPTH (mcpwm_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan status of the entry just read back
    assign hit       = chk_vld_reg && (ram_rdata.pin == pin_reg);
    assign exhausted = !chk_vld_reg && (rd_idx_reg == used_reg);
    assign tick_last = chk_vld_reg
                    && ((COUNT_W'(chk_idx_reg) + COUNT_W'(1)) == used_reg);
    assign scan_done = (req_reg == mcpwm_pkg::REQ_TICK) ? tick_last : (hit || exhausted);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcpwm_pkg::ST_IDLE:
            begin
                if (accept && ((req_type == mcpwm_pkg::REQ_SET) || (used_reg != '0)))
                begin
                    state_next = mcpwm_pkg::ST_SCAN;
                end
            end
            mcpwm_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = mcpwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcpwm_pkg::ST_IDLE;
            end
        endcase
    end

    // memory control and result generation
    always_comb
    begin
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg[SLOT_W-1:0];
        ram_we       = 1'b0;
        ram_waddr    = chk_idx_reg;
        ram_wdata    = '{pin: pin_reg, duty: duty_reg};
        used_inc     = 1'b0;
        valid_next   = 1'b0;
        kind_next    = mcpwm_pkg::KIND_STATUS;
        status_next  = mcpwm_pkg::STAT_UPDATED;
        slot_next    = chk_idx_reg;
        pin_out_next = pin_reg;
        level_next   = 1'b0;
        last_next    = 1'b1;
        case (state_reg)
            mcpwm_pkg::ST_IDLE:
            begin
                ram_re = 1'b0;
            end
            mcpwm_pkg::ST_SCAN:
            begin
                ram_re = (rd_idx_reg < used_reg);
                if (req_reg == mcpwm_pkg::REQ_TICK)
                begin
                    valid_next   = chk_vld_reg;
                    kind_next    = mcpwm_pkg::KIND_LEVEL;
                    pin_out_next = ram_rdata.pin;
                    level_next   = (phase_reg < ram_rdata.duty);
                    last_next    = tick_last;
                end
                else if (hit)
                begin
                    ram_we     = 1'b1;
                    valid_next = 1'b1;
                end
                else if (exhausted)
                begin
                    valid_next = 1'b1;
                    if (used_reg < TABLE_CAP)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = used_reg[SLOT_W-1:0];
                        used_inc    = 1'b1;
                        status_next = mcpwm_pkg::STAT_ALLOCATED;
                        slot_next   = used_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        status_next = mcpwm_pkg::STAT_FULL;
                        slot_next   = '0;
                    end
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // counters of the scan pipeline
    always_comb
    begin
        phase_next   = phase_reg;
        used_next    = used_inc ? (used_reg + COUNT_W'(1)) : used_reg;
        rd_idx_next  = rd_idx_reg;
        chk_vld_next = ram_re && !scan_done;
        if (accept)
        begin
            rd_idx_next = '0;
            if (req_type == mcpwm_pkg::REQ_TICK)
            begin
                phase_next = phase_reg + 8'd1;
            end
        end
        else if (ram_re)
        begin
            rd_idx_next = rd_idx_reg + COUNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mcpwm_pkg::ST_IDLE;
            phase_reg   <= '0;
            used_reg    <= '0;
            rd_idx_reg  <= '0;
            chk_vld_reg <= 1'b0;
            req_reg     <= mcpwm_pkg::REQ_SET;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            used_reg    <= used_next;
            rd_idx_reg  <= rd_idx_next;
            chk_vld_reg <= chk_vld_next;
            valid_reg   <= valid_next;
            if (accept)
            begin
                req_reg <= req_type;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg  <= pin_id;
            duty_reg <= duty;
        end
        chk_idx_reg <= rd_idx_reg[SLOT_W-1:0];
        kind_reg    <= kind_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        pin_out_reg <= pin_out_next;
        level_reg   <= level_next;
        last_reg    <= last_next;
    end

    assign valid   = valid_reg;
    assign kind    = kind_reg;
    assign status  = status_reg;
    assign slot    = slot_reg;
    assign out_pin = pin_out_reg;
    assign level   = level_reg;
    assign last    = last_reg;

    // checks on the sequencer
    `MCPWM_ASSERT_SAME(a_used_cap, clk, rst_n, 1'b1, used_reg <= TABLE_CAP)
    `MCPWM_ASSERT_SAME(a_last_ends, clk, rst_n, valid_reg, last_reg == !busy)
    `MCPWM_ASSERT_SAME(a_status_single, clk, rst_n,
        valid_reg && (kind_reg == mcpwm_pkg::KIND_STATUS), last_reg)
    `MCPWM_ASSERT_SAME(a_write_in_scan, clk, rst_n, ram_we,
        (state_reg == mcpwm_pkg::ST_SCAN) && (req_reg == mcpwm_pkg::REQ_SET))
    `MCPWM_ASSERT_NEXT(a_tick_empty, clk, rst_n,
        accept && (req_type == mcpwm_pkg::REQ_TICK) && (used_reg == '0), !busy)

endmodule

`default_nettype wire

// File: dv/multi_channel_soft_pwm_check.sv
`default_nettype none

module multi_channel_soft_pwm_check #(
    parameter int CHANNELS = mcpwm_pkg::DEF_CHANNELS
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire                             busy,
    input  wire                             req_type,
    input  wire  [mcpwm_pkg::PIN_W-1:0]     pin_id,
    input  wire  [mcpwm_pkg::DUTY_W-1:0]    duty,
    input  wire                             valid,
    input  wire                             kind,
    input  wire  [1:0]                      status,
    input  wire  [mcpwm_pkg::SLOT_W-1:0]    slot,
    input  wire  [mcpwm_pkg::PIN_W-1:0]     out_pin,
    input  wire                             level,
    input  wire                             last,
    output int                              errors,
    output int                              pending,
    output int                              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = mcpwm_pkg::TABLE_DEPTH;
    localparam int SLOT_W      = mcpwm_pkg::SLOT_W;
    localparam int COUNT_W     = mcpwm_pkg::COUNT_W;
    localparam int PIN_W       = mcpwm_pkg::PIN_W;
    localparam int DUTY_W      = mcpwm_pkg::DUTY_W;
    localparam int CAP = (CHANNELS < TABLE_DEPTH) ? CHANNELS : TABLE_DEPTH;

    // one expected output transaction
    typedef struct {
        logic              kind;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [PIN_W-1:0]  pin;
        logic              level;
        logic              last;
    } pwm_result_t;

    // shadow copy of the channel table and phase
    logic [7:0]         shadow_phase;
    logic [COUNT_W-1:0] shadow_used;
    logic [PIN_W-1:0]   shadow_pins [TABLE_DEPTH];
    logic [DUTY_W-1:0]  shadow_duties [TABLE_DEPTH];

    pwm_result_t expected_results [$];

    // work out the results of one accepted request and update the shadow table
    task automatic apply_request(input logic rt, input logic [PIN_W-1:0] pin,
                                 input logic [DUTY_W-1:0] d);
        int used;
        bit found;
        pwm_result_t r;
        used = (shadow_used > CAP) ? CAP : int'(shadow_used);
        found = 0;
        if (rt == mcpwm_pkg::REQ_SET)
        begin
            r.kind  = mcpwm_pkg::KIND_STATUS;
            r.pin   = pin;
            r.level = 1'b0;
            r.last  = 1'b1;
            for (int s = 0; s < used; s++)
            begin
                if (!found && shadow_pins[s] == pin)
                begin
                    found = 1;
                    shadow_duties[s] = d;
                    r.status = mcpwm_pkg::STAT_UPDATED;
                    r.slot   = SLOT_W'(s);
                end
            end
            if (!found)
            begin
                if (used < CAP)
                begin
                    shadow_pins[used]   = pin;
                    shadow_duties[used] = d;
                    shadow_used         = COUNT_W'(used + 1);
                    r.status = mcpwm_pkg::STAT_ALLOCATED;
                    r.slot   = SLOT_W'(used);
                end
                else
                begin
                    r.status = mcpwm_pkg::STAT_FULL;
                    r.slot   = '0;
                end
            end
            expected_results.push_back(r);
        end
        else
        begin
            shadow_phase = shadow_phase + 8'd1;
            for (int s = 0; s < used; s++)
            begin
                r.kind   = mcpwm_pkg::KIND_LEVEL;
                r.status = mcpwm_pkg::STAT_UPDATED;
                r.slot   = SLOT_W'(s);
                r.pin    = shadow_pins[s];
                r.level  = (shadow_phase < shadow_duties[s]);
                r.last   = (s + 1 == used);
                expected_results.push_back(r);
            end
        end
    endtask

    function automatic int field_diff(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // compare results first, then predict any newly accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        pwm_result_t e;
        int bad;
        if (!rst_n)
        begin
            shadow_phase = '0;
            shadow_used  = '0;
            expected_results.delete();
            errors  = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (valid === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d pin 0x%0h",
                             $time, kind, out_pin);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    bad = 0;
                    bad += field_diff("kind", 8'(e.kind), 8'(kind));
                    bad += field_diff("status", 8'(e.status), 8'(status));
                    bad += field_diff("slot", 8'(e.slot), 8'(slot));
                    bad += field_diff("out_pin", e.pin, out_pin);
                    bad += field_diff("level", 8'(e.level), 8'(level));
                    bad += field_diff("last", 8'(e.last), 8'(last));
                    if (bad != 0)
                        errors++;
                    checked++;
                end
            end
            else if (valid !== 1'b0)
            begin
                $display("%0t: valid unknown, expected 0 or 1, actual %b", $time, valid);
                errors++;
            end
            if (start && busy === 1'b0)
                apply_request(req_type, pin_id, duty);
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

// File: dv/multi_channel_soft_pwm_test.sv
`default_nettype none

module multi_channel_soft_pwm_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_W = mcpwm_pkg::SLOT_W;
    localparam int PIN_W  = mcpwm_pkg::PIN_W;
    localparam int DUTY_W = mcpwm_pkg::DUTY_W;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                req_type;
    logic [PIN_W-1:0]    pin_id;
    logic [DUTY_W-1:0]   duty;
    wire                 busy;
    wire                 valid;
    wire                 kind;
    wire  [1:0]          status;
    wire  [SLOT_W-1:0]   slot;
    wire  [PIN_W-1:0]    out_pin;
    wire                 level;
    wire                 last;

    int errors;
    int pending;
    int checked;
    int n_set;
    int n_tick;
    bit no_idle;

    // pins that end up in the table during the directed part
    logic [PIN_W-1:0] table_pins [8] = '{8'h00, 8'hFF, 8'hA5, 8'h5A,
                                         8'h0F, 8'hF0, 8'h12, 8'h34};

    multi_channel_soft_pwm u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .pin_id   (pin_id),
        .duty     (duty),
        .valid    (valid),
        .kind     (kind),
        .status   (status),
        .slot     (slot),
        .out_pin  (out_pin),
        .level    (level),
        .last     (last)
    );

    multi_channel_soft_pwm_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .pin_id   (pin_id),
        .duty     (duty),
        .valid    (valid),
        .kind     (kind),
        .status   (status),
        .slot     (slot),
        .out_pin  (out_pin),
        .level    (level),
        .last     (last),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request transaction, with a random hold-off before it unless no_idle is set
    task automatic send_request(input logic rt, input logic [PIN_W-1:0] pin,
                                input logic [DUTY_W-1:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= rt;
        pin_id   <= pin;
        duty     <= d;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        if (rt == mcpwm_pkg::REQ_SET)
            n_set++;
        else
            n_tick++;
    endtask

    // stimulus
    initial
    begin
        int idx;
        logic [DUTY_W-1:0] d;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = mcpwm_pkg::REQ_SET;
        pin_id   = '0;
        duty     = '0;
        n_set    = 0;
        n_tick   = 0;
        no_idle  = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ticks on an empty table only advance the phase
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        send_request(mcpwm_pkg::REQ_TICK, 8'hFF, 8'hFF);
        // allocate, tick, then update an existing pin
        send_request(mcpwm_pkg::REQ_SET, table_pins[0], 8'h00);
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        send_request(mcpwm_pkg::REQ_SET, table_pins[1], 8'hFF);
        send_request(mcpwm_pkg::REQ_SET, table_pins[0], 8'h80);
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        // fill the rest of the table
        send_request(mcpwm_pkg::REQ_SET, table_pins[2], 8'h01);
        send_request(mcpwm_pkg::REQ_SET, table_pins[3], 8'hFE);
        send_request(mcpwm_pkg::REQ_SET, table_pins[4], 8'h03);
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        send_request(mcpwm_pkg::REQ_SET, table_pins[5], 8'h02);
        send_request(mcpwm_pkg::REQ_SET, table_pins[6], 8'h7F);
        send_request(mcpwm_pkg::REQ_SET, table_pins[7], 8'h00);
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        // table full, then updates of the last, second and first slots
        send_request(mcpwm_pkg::REQ_SET, 8'h99, 8'h55);
        send_request(mcpwm_pkg::REQ_SET, 8'h66, 8'hAA);
        send_request(mcpwm_pkg::REQ_SET, table_pins[7], 8'hFF);
        send_request(mcpwm_pkg::REQ_SET, table_pins[1], 8'hFF);
        send_request(mcpwm_pkg::REQ_SET, table_pins[0], 8'h00);
        send_request(mcpwm_pkg::REQ_TICK, 8'h00, 8'h00);
        send_request(mcpwm_pkg::REQ_TICK, 8'hFF, 8'hFF);

        // random part, mostly ticks so the phase wraps
        for (int i = 0; i < 330; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                no_idle = ~no_idle;
            case ($urandom_range(0, 7))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = DUTY_W'($urandom);
            endcase
            if ($urandom_range(0, 99) < 80)
            begin
                send_request(mcpwm_pkg::REQ_TICK, PIN_W'($urandom), DUTY_W'($urandom));
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                // keep slot 1 at full duty so the top of the phase range shows
                idx = $urandom_range(0, 6);
                if (idx >= 1)
                    idx++;
                send_request(mcpwm_pkg::REQ_SET, table_pins[idx], d);
            end
            else
            begin
                send_request(mcpwm_pkg::REQ_SET, PIN_W'($urandom), d);
            end
        end
        start <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d set-duty and %0d tick transactions, %0d results checked",
                 n_set, n_tick, checked);
        $display("table filled to capacity, full rejects and updates exercised");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
